// ===== sv/tjmp_pkg.sv =====
// ----------------------------------------------------------------------------
// tjmp_pkg
// Shared types, constants and helpers of the joint motion profiler.
// ----------------------------------------------------------------------------
package tjmp_pkg;

  localparam int JOINTS    = 7;
  localparam int NFIELDS   = 7;
  localparam int AW        = 16;
  localparam int SW        = 17;
  localparam int ATW       = 12;
  localparam int JW        = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam int CFG_IW    = 3;
  localparam int DIV_STEPS = 17;
  localparam int DCW       = $clog2(DIV_STEPS + 1);
  localparam int BASE_ATTEMPTS = 12;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_ACCEL  = 3'd1,
    PH_CRUISE = 3'd2,
    PH_DECEL  = 3'd3,
    PH_FINISH = 3'd4
  } phase_e;

  typedef enum logic [CFG_IW-1:0] {
    CFG_MIN_SPEED = 3'd0,
    CFG_MAX_SPEED = 3'd1,
    CFG_TOLERANCE = 3'd2,
    CFG_STEP_UP   = 3'd3,
    CFG_STEP_DOWN = 3'd4
  } cfg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_UPD,
    S_DIV_GO,
    S_DIV_WAIT,
    S_MUL,
    S_OUT
  } state_e;

  localparam logic OP_GOAL = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic                 operation;
    logic signed [AW-1:0] joint_angle_0;
    logic signed [AW-1:0] joint_angle_1;
    logic signed [AW-1:0] joint_angle_2;
    logic signed [AW-1:0] joint_angle_3;
    logic signed [AW-1:0] joint_angle_4;
    logic signed [AW-1:0] joint_angle_5;
    logic signed [AW-1:0] joint_angle_6;
  } in_item_t;

  typedef struct packed {
    logic          command_valid;
    logic          goal_reached;
    logic [2:0]    phase;
    logic [AW-1:0] joint_speed_0;
    logic [AW-1:0] joint_speed_1;
    logic [AW-1:0] joint_speed_2;
    logic [AW-1:0] joint_speed_3;
    logic [AW-1:0] joint_speed_4;
    logic [AW-1:0] joint_speed_5;
    logic [AW-1:0] joint_speed_6;
  } out_item_t;

  typedef logic [JOINTS-1:0][AW-1:0] lanes_t;
  typedef logic [JOINTS-1:0][SW-1:0] shares_t;
  typedef logic [NFIELDS-1:0][AW-1:0] fields_t;

  typedef struct packed {
    logic          load_goal;
    logic          load_meas;
    logic          err_step;
    logic          update;
    logic          div_start;
    logic          share_wr;
    logic          mul_step;
    logic          out_load;
    logic [JW-1:0] idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic start_move;
    logic err_zero;
    logic div_done;
    logic out_free;
  } dp_status_t;

  function automatic lanes_t item_lanes(input in_item_t it);
    fields_t f;
    lanes_t  l;
    f = {it.joint_angle_6, it.joint_angle_5, it.joint_angle_4, it.joint_angle_3,
         it.joint_angle_2, it.joint_angle_1, it.joint_angle_0};
    l = '0;
    for (int j = 0; j < JOINTS; j++) begin
      if (j < NFIELDS) begin
        l[j] = f[j];
      end
    end
    return l;
  endfunction

endpackage

// ===== sv/tjmp_div.sv =====
// ----------------------------------------------------------------------------
// tjmp_div
// Restoring divider, one quotient bit per cycle, for the joint share ratio.
// ----------------------------------------------------------------------------
module tjmp_div
  import tjmp_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [AW-1:0] num_i,
  input  logic [AW-1:0] den_i,
  output logic          done_o,
  output logic [SW-1:0] quo_o
);

  logic [SW-1:0]  rem_q, rem_d;
  logic [SW-1:0]  quo_q, quo_d;
  logic [AW-1:0]  den_q, den_d;
  logic [DCW-1:0] cnt_q, cnt_d;
  logic           run_q, run_d;
  logic           done_q, done_d;
  logic           bit_s;
  logic [SW-1:0]  rsub;

  always_comb begin
    bit_s  = (rem_q >= {1'b0, den_q});
    rsub   = bit_s ? (rem_q - {1'b0, den_q}) : rem_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = {1'b0, num_i};
      den_d = den_i;
      quo_d = '0;
      cnt_d = DCW'(DIV_STEPS);
      run_d = 1'b1;
    end else if (run_q) begin
      quo_d = {quo_q[SW-2:0], bit_s};
      rem_d = {rsub[SW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DCW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== sv/tjmp_dp.sv =====
// ----------------------------------------------------------------------------
// tjmp_dp
// Datapath: configuration, goal and measured angles, phase update, shares,
// joint speed multiply and the output register.
// ----------------------------------------------------------------------------
module tjmp_dp
  import tjmp_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [AW-1:0]   cfg_data_i,
  input  in_item_t        in_data_i,
  input  logic            out_stall_i,
  input  ctrl_cmd_t       cmd_i,
  output dp_status_t      st_o,
  output logic            out_valid_o,
  output out_item_t       out_data_o
);

  logic [AW-1:0] min_q, max_q, tol_q, up_q, down_q;
  lanes_t        goal_q, meas_q, speed_q;
  shares_t       share_q;
  phase_e        phase_q, phase_d;
  logic          pend_q, pend_d;
  logic [SW-1:0] cs_q, cs_d;
  logic [ATW-1:0] att_q, att_d;
  logic [AW-1:0] err_q;
  logic          cmd_q, cmd_d;
  logic          reached_q, reached_d;
  logic          out_valid_q;
  out_item_t     out_q;

  logic signed [AW:0] dsub;
  logic [AW-1:0]  diff;
  logic           div_done;
  logic [SW-1:0]  div_quo;
  logic [SW:0]    cs_up;
  logic [SW:0]    floor_sum;
  logic [SW-1:0]  cs_new;
  logic [AW+3:0]  err16;
  logic [SW+3:0]  cs10;
  logic [ATW-1:0] att1;
  logic [AW+5:0]  err60;
  logic           start_move;
  logic [2*SW-1:0] prod;
  logic [SW+1:0]  prod_hi;
  fields_t        spd_f;

  always_comb begin
    dsub = $signed({goal_q[cmd_i.idx][AW-1], goal_q[cmd_i.idx]})
         - $signed({meas_q[cmd_i.idx][AW-1], meas_q[cmd_i.idx]});
    diff = dsub[AW] ? AW'(-dsub) : dsub[AW-1:0];
  end

  tjmp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (diff),
    .den_i   (err_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  assign start_move = !(phase_q == PH_ACCEL || phase_q == PH_CRUISE ||
                        phase_q == PH_DECEL || phase_q == PH_FINISH) && pend_q;

  always_comb begin
    cs_up     = {1'b0, cs_q} + {2'b0, up_q};
    floor_sum = {2'b0, down_q} + {2'b0, min_q};
    cs_new    = cs_q;
    phase_d   = phase_q;
    pend_d    = pend_q;
    cs_d      = cs_q;
    att_d     = att_q;
    cmd_d     = 1'b0;
    reached_d = 1'b0;
    att1      = (att_q != '0) ? att_q - 1'b1 : att_q;
    err60     = {err_q, 6'b0} - {4'b0, err_q, 2'b0};
    case (phase_q)
      PH_ACCEL: begin
        cs_new = cs_up[SW] ? {SW{1'b1}} : cs_up[SW-1:0];
      end
      PH_DECEL: begin
        cs_new = ({1'b0, cs_q} >= floor_sum) ? cs_q - {1'b0, down_q} : {1'b0, min_q};
      end
      default: begin
        cs_new = cs_q;
      end
    endcase
    err16 = {err_q, 4'b0};
    cs10  = {1'b0, cs_new, 3'b0} + {3'b0, cs_new, 1'b0};
    if (cmd_i.load_goal) begin
      pend_d = 1'b1;
    end
    if (cmd_i.update) begin
      case (phase_q)
        PH_ACCEL: begin
          cs_d = cs_new;
          if (err_q < tol_q) begin
            phase_d = PH_FINISH;
          end else begin
            if ({1'b0, err16} < cs10) begin
              phase_d = PH_DECEL;
            end else if (cs_new >= {1'b0, max_q}) begin
              phase_d = PH_CRUISE;
            end
            cmd_d = 1'b1;
          end
          att_d = att1;
          if (att1 == '0) phase_d = PH_FINISH;
        end
        PH_CRUISE: begin
          if ({1'b0, err16} < cs10) phase_d = PH_DECEL;
          cmd_d = 1'b1;
          att_d = att1;
          if (att1 == '0) phase_d = PH_FINISH;
        end
        PH_DECEL: begin
          cs_d = cs_new;
          if (err_q < tol_q) phase_d = PH_FINISH;
          cmd_d = 1'b1;
          att_d = att1;
          if (att1 == '0) phase_d = PH_FINISH;
        end
        PH_FINISH: begin
          phase_d   = PH_IDLE;
          reached_d = 1'b1;
        end
        default: begin
          phase_d = PH_IDLE;
          cs_d    = '0;
          if (pend_q) begin
            pend_d  = 1'b0;
            phase_d = PH_ACCEL;
            att_d   = ATW'(BASE_ATTEMPTS) + ATW'(err60[AW+5:12]);
          end
        end
      endcase
    end
  end

  always_comb begin
    prod    = cs_q * share_q[cmd_i.idx];
    prod_hi = prod[2*SW-1:AW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q       <= AW'(655);
      max_q       <= AW'(9830);
      tol_q       <= AW'(205);
      up_q        <= AW'(216);
      down_q      <= AW'(216);
      phase_q     <= PH_IDLE;
      pend_q      <= 1'b0;
      cs_q        <= '0;
      att_q       <= '0;
      share_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MIN_SPEED: min_q  <= cfg_data_i;
          CFG_MAX_SPEED: max_q  <= cfg_data_i;
          CFG_TOLERANCE: tol_q  <= cfg_data_i;
          CFG_STEP_UP:   up_q   <= cfg_data_i;
          CFG_STEP_DOWN: down_q <= cfg_data_i;
          default: ;
        endcase
      end
      phase_q <= phase_d;
      pend_q  <= pend_d;
      cs_q    <= cs_d;
      att_q   <= att_d;
      if (cmd_i.update && start_move) begin
        share_q <= '0;
      end
      if (cmd_i.share_wr) begin
        share_q[cmd_i.idx] <= div_quo;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    spd_f = '0;
    for (int k = 0; k < NFIELDS; k++) begin
      if (k < JOINTS && cmd_q) begin
        spd_f[k] = speed_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_goal) begin
      goal_q <= item_lanes(in_data_i);
    end
    if (cmd_i.load_meas) begin
      meas_q <= item_lanes(in_data_i);
    end
    if (cmd_i.err_step) begin
      err_q <= (cmd_i.idx == '0 || diff > err_q) ? diff : err_q;
    end
    if (cmd_i.update) begin
      cmd_q     <= cmd_d;
      reached_q <= reached_d;
    end
    if (cmd_i.mul_step) begin
      speed_q[cmd_i.idx] <= (prod_hi > (SW+1)'(16'hFFFF)) ? 16'hFFFF : prod_hi[AW-1:0];
    end
    if (cmd_i.out_load) begin
      out_q.command_valid <= cmd_q;
      out_q.goal_reached  <= reached_q;
      out_q.phase         <= phase_q;
      out_q.joint_speed_0 <= spd_f[0];
      out_q.joint_speed_1 <= spd_f[1];
      out_q.joint_speed_2 <= spd_f[2];
      out_q.joint_speed_3 <= spd_f[3];
      out_q.joint_speed_4 <= spd_f[4];
      out_q.joint_speed_5 <= spd_f[5];
      out_q.joint_speed_6 <= spd_f[6];
    end
  end

  assign st_o.start_move = start_move;
  assign st_o.err_zero   = (err_q == '0);
  assign st_o.div_done   = div_done;
  assign st_o.out_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

endmodule

// ===== sv/tjmp_ctrl.sv =====
// ----------------------------------------------------------------------------
// tjmp_ctrl
// Sequencer: error scan, phase update, share division, speed multiply and output load.
// ----------------------------------------------------------------------------
module tjmp_ctrl
  import tjmp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_op_i,
  output logic       in_stall_o,
  input  dp_status_t st_i,
  output ctrl_cmd_t  cmd_o
);

  state_e        state_q, state_d;
  logic [JW-1:0] idx_q, idx_d;
  logic          last;

  assign last = (idx_q == JW'(JOINTS - 1));

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      S_IDLE: begin
        idx_d = '0;
        if (in_valid_i && in_op_i == OP_TICK) state_d = S_ERR;
      end
      S_ERR: begin
        idx_d = last ? '0 : idx_q + 1'b1;
        if (last) state_d = S_UPD;
      end
      S_UPD: begin
        idx_d   = '0;
        state_d = (st_i.start_move && !st_i.err_zero) ? S_DIV_GO : S_MUL;
      end
      S_DIV_GO: begin
        state_d = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (st_i.div_done) begin
          idx_d   = last ? '0 : idx_q + 1'b1;
          state_d = last ? S_MUL : S_DIV_GO;
        end
      end
      S_MUL: begin
        idx_d = last ? '0 : idx_q + 1'b1;
        if (last) state_d = S_OUT;
      end
      S_OUT: begin
        if (st_i.out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o     = '0;
    cmd_o.idx = idx_q;
    case (state_q)
      S_IDLE: begin
        cmd_o.load_goal = in_valid_i && in_op_i == OP_GOAL;
        cmd_o.load_meas = in_valid_i && in_op_i == OP_TICK;
      end
      S_ERR:      cmd_o.err_step  = 1'b1;
      S_UPD:      cmd_o.update    = 1'b1;
      S_DIV_GO:   cmd_o.div_start = 1'b1;
      S_DIV_WAIT: cmd_o.share_wr  = st_i.div_done;
      S_MUL:      cmd_o.mul_step  = 1'b1;
      S_OUT:      cmd_o.out_load  = st_i.out_free;
      default: ;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

// ===== sv/trapezoid_joint_motion_profiler_unit.sv =====
// ----------------------------------------------------------------------------
// trapezoid_joint_motion_profiler_unit
// Seven-joint trapezoidal speed profiler, controller plus datapath.
// ----------------------------------------------------------------------------
// Goal transfer: taken while idle, no result.
// Tick transfer: error scan, update, multiply, then load into the output
// register; a tick that starts a move with nonzero error also runs the
// serial divider once per joint between update and multiply.
// One item at a time; the next is taken while a result waits to transfer.
// Reset clears phase, pending flag, common speed, shares, budget and the output valid flag.
module trapezoid_joint_motion_profiler_unit
  import tjmp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [AW-1:0]     cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_item_t         out_data_o
);

  ctrl_cmd_t  cmd;
  dp_status_t st;

  tjmp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_data_i.operation),
    .in_stall_o (in_stall_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  tjmp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .st_o        (st),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
